/* rtl/core/mst_pkg.sv */
package mst_pkg;

    // Operation codes carried in the func field of an input item.
    typedef enum logic [1:0] {
        FUNC_ATTACH = 2'd0,
        FUNC_DETACH = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QCALC,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Seconds to milliseconds.
    localparam logic [31:0] MS_PER_SEC = 32'd1000;

    // One input item.
    typedef struct packed {
        t_func       func;
        logic [3:0]  slot;
        logic [31:0] interval;
        logic        interval_in_seconds;
        logic [15:0] repeat_count;
    } t_item;

    // One result item.
    typedef struct packed {
        logic        status;
        logic        fired;
        logic [3:0]  fired_slot;
        logic [31:0] remaining;
        logic [4:0]  active_count;
        logic        last;
    } t_result;

    // One entry of the slot memory.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] interval;
        logic [15:0] repeats;
    } t_slot_entry;

endpackage

/* rtl/core/multi_slot_repeat_timer.sv */
// Timer table of SLOTS slots on a 32-bit millisecond counter. An item is taken
// when start is high and busy is low; each result appears for one cycle with
// o_strobe and cannot be held off. Attach and detach answer in the next cycle
// and never raise busy, so they may be issued back to back. A query keeps busy
// high through its read state and its calculate state and answers as busy
// falls. A tick scans the slot memory one slot per cycle through its single
// read and single write port, then walks the slot indexes in order up to the
// last fired slot, sending one result for each fired slot, or one empty result,
// with last on the final one. Results carry the active slot count after the
// whole tick.
module multi_slot_repeat_timer import mst_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    t_state            r_state, n_state;
    logic [31:0]       r_now, n_now;
    logic [SLOTS-1:0]  r_act, n_act;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pv, n_pv;
    logic [SW-1:0]     r_pidx, n_pidx;
    logic [SLOTS-1:0]  r_mask, n_mask;
    logic [31:0]       r_el, n_el;
    logic              r_qhit, n_qhit;
    logic              r_strobe, n_strobe;
    t_result           r_res, n_res;

    logic              mem_we, mem_re;
    logic [SW-1:0]     mem_waddr, mem_raddr;
    t_slot_entry       mem_wdata, mem_rdata;

    logic              accept;
    logic              in_range;
    logic [SW-1:0]     slot_a;
    logic [31:0]       scan_el;
    logic [32:0]       q_diff;

    mst_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(i_item.slot) < SLOTS);
    assign slot_a   = SW'(i_item.slot);
    assign scan_el  = r_now - mem_rdata.start;
    assign q_diff   = {1'b0, mem_rdata.interval} - {1'b0, r_el};

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_now    <= '0;
            r_act    <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_act    <= n_act;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            r_mask   <= n_mask;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_el   <= n_el;
        r_qhit <= n_qhit;
        r_res  <= n_res;
    end

    // Next state, memory accesses and results.
    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_act     = r_act;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_mask    = r_mask;
        n_el      = r_el;
        n_qhit    = r_qhit;
        n_strobe  = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = slot_a;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = slot_a;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    n_res.last = 1'b1;
                    case (i_item.func)
                        FUNC_ATTACH: begin
                            n_res.status = STATUS_FAIL;
                            if (in_range) begin
                                // The slot restarts even when it was already armed.
                                mem_we             = 1'b1;
                                mem_wdata.start    = r_now;
                                mem_wdata.interval = i_item.interval_in_seconds ?
                                    32'(i_item.interval * MS_PER_SEC) : i_item.interval;
                                mem_wdata.repeats  = i_item.repeat_count;
                                if (!r_act[slot_a]) begin
                                    n_act[slot_a] = 1'b1;
                                    n_cnt         = r_cnt + CW'(1);
                                    n_res.status  = STATUS_OK;
                                end
                            end
                            n_res.active_count = 5'(n_cnt);
                            n_strobe           = 1'b1;
                        end
                        FUNC_DETACH: begin
                            n_res.status = STATUS_FAIL;
                            if (in_range && r_act[slot_a]) begin
                                n_act[slot_a] = 1'b0;
                                n_cnt         = r_cnt - CW'(1);
                                n_res.status  = STATUS_OK;
                            end
                            n_res.active_count = 5'(n_cnt);
                            n_strobe           = 1'b1;
                        end
                        FUNC_QUERY: begin
                            mem_re  = 1'b1;
                            n_qhit  = in_range && r_act[slot_a];
                            n_state = ST_QREAD;
                        end
                        FUNC_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_idx   = '0;
                            n_pv    = 1'b0;
                            n_mask  = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // Query: elapsed time first, then the remainder against the interval.
            ST_QREAD: begin
                n_el    = scan_el;
                n_state = ST_QCALC;
            end

            ST_QCALC: begin
                n_res              = '0;
                n_res.last         = 1'b1;
                n_res.active_count = 5'(r_cnt);
                if (r_qhit && !q_diff[32]) begin
                    n_res.remaining = q_diff[31:0];
                end
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end

            // Scan: read slot r_idx while slot r_pidx, read last cycle, is updated.
            ST_SCAN: begin
                if (r_idx < CW'(SLOTS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[SW-1:0];
                    n_pv      = 1'b1;
                    n_pidx    = r_idx[SW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_pv    = 1'b0;
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end
                if (r_pv && r_act[r_pidx] && (scan_el >= mem_rdata.interval)) begin
                    mem_we          = 1'b1;
                    mem_waddr       = r_pidx;
                    mem_wdata.start = mem_rdata.start + mem_rdata.interval;
                    if (mem_rdata.repeats != 16'd0) begin
                        mem_wdata.repeats = mem_rdata.repeats - 16'd1;
                        if (mem_rdata.repeats == 16'd1) begin
                            n_act[r_pidx] = 1'b0;
                            n_cnt         = r_cnt - CW'(1);
                        end
                    end
                    n_mask[r_pidx] = 1'b1;
                end
            end

            // Emit: walk the fired mask in index order, one transfer per fired slot.
            ST_EMIT: begin
                n_res              = '0;
                n_res.active_count = 5'(r_cnt);
                if (r_mask == '0) begin
                    n_res.last = 1'b1;
                    n_strobe   = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    if (r_mask[r_idx[SW-1:0]]) begin
                        n_mask[r_idx[SW-1:0]] = 1'b0;
                        n_res.fired           = 1'b1;
                        n_res.fired_slot      = 4'(r_idx);
                        n_res.last            = (n_mask == '0);
                        n_strobe              = 1'b1;
                        if (n_mask == '0) begin
                            n_state = ST_IDLE;
                        end
                    end
                    n_idx = r_idx + CW'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    // The active count always matches the number of armed slots.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'($countones(r_act)))
        else $error("active count differs from the armed slot bits");

    // An empty result is always the only and final one of its step.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.fired |-> o_result.last)
        else $error("result without a fire is not marked last");

    // Busy drops only together with the final transfer of the step.
    a_busy_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe && o_result.last)
        else $error("busy dropped without the final transfer");

    // A fired slot always lies inside the table.
    a_fired_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.fired |-> (32'(o_result.fired_slot) < SLOTS))
        else $error("fired slot outside the table");
`endif

endmodule

/* rtl/core/mst_slot_mem.sv */
module mst_slot_mem import mst_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot_entry   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot_entry   o_rdata
);

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/tb_top.sv */
module tb_top;
    import mst_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 127;
    // The last items are sent back to back.
    localparam int TAIL_ITEMS   = 30;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_strobe;
    t_result o_result;

    // Items waiting to be driven and results the timer table should produce.
    t_item   pending_items[$];
    t_result expected_results[$];

    // Shadow copy of the timer table.
    logic [31:0] clock_ms;
    logic [31:0] slot_start_ms  [SLOTS];
    logic [31:0] slot_period_ms [SLOTS];
    logic [15:0] slot_reps_left [SLOTS];
    logic        slot_armed     [SLOTS];
    logic [4:0]  armed_total;

    int total_items    = 0;
    int accepted_count = 0;
    int idle_left      = 0;
    int error_count    = 0;
    int func_count[4]  = '{0, 0, 0, 0};
    int fire_count     = 0;
    int max_fires      = 0;

    multi_slot_repeat_timer #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_item make_item(t_func func, logic [3:0] slot, logic [31:0] ival,
                                        logic secs, logic [15:0] reps);
        t_item it;
        it.func                = func;
        it.slot                = slot;
        it.interval            = ival;
        it.interval_in_seconds = secs;
        it.repeat_count        = reps;
        return it;
    endfunction

    // Clear the shadow table as reset does.
    task automatic clear_timer_table();
        clock_ms    = '0;
        armed_total = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_start_ms[i]  = '0;
            slot_period_ms[i] = '0;
            slot_reps_left[i] = '0;
            slot_armed[i]     = 1'b0;
        end
    endtask

    // Apply one accepted item to the shadow table and queue the results it causes.
    task automatic timer_table_step(input t_item it);
        t_result    res;
        logic [31:0] elapsed;
        logic [3:0] fired_list[SLOTS];
        int         n_fired;
        n_fired = 0;
        res = '0;
        func_count[it.func]++;
        case (it.func)
            FUNC_ATTACH: begin
                res.status = STATUS_FAIL;
                slot_start_ms[it.slot]  = clock_ms;
                slot_period_ms[it.slot] = it.interval_in_seconds ?
                                          it.interval * MS_PER_SEC : it.interval;
                slot_reps_left[it.slot] = it.repeat_count;
                if (!slot_armed[it.slot]) begin
                    slot_armed[it.slot] = 1'b1;
                    armed_total++;
                    res.status = STATUS_OK;
                end
                res.active_count = armed_total;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            FUNC_DETACH: begin
                res.status = STATUS_FAIL;
                if (slot_armed[it.slot]) begin
                    slot_armed[it.slot] = 1'b0;
                    armed_total--;
                    res.status = STATUS_OK;
                end
                res.active_count = armed_total;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            FUNC_QUERY: begin
                if (slot_armed[it.slot]) begin
                    elapsed = clock_ms - slot_start_ms[it.slot];
                    if (elapsed < slot_period_ms[it.slot])
                        res.remaining = slot_period_ms[it.slot] - elapsed;
                end
                res.active_count = armed_total;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            default: begin
                // Tick: advance time, then scan slots in index order.
                clock_ms = clock_ms + 32'd1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_armed[i] &&
                        (clock_ms - slot_start_ms[i]) >= slot_period_ms[i]) begin
                        slot_start_ms[i] = slot_start_ms[i] + slot_period_ms[i];
                        if (slot_reps_left[i] != 16'd0) begin
                            slot_reps_left[i]--;
                            if (slot_reps_left[i] == 16'd0) begin
                                slot_armed[i] = 1'b0;
                                armed_total--;
                            end
                        end
                        fired_list[n_fired] = 4'(i);
                        n_fired++;
                    end
                end
                if (n_fired == 0) begin
                    res.active_count = armed_total;
                    res.last = 1'b1;
                    expected_results.push_back(res);
                end
                for (int k = 0; k < n_fired; k++) begin
                    res = '0;
                    res.fired        = 1'b1;
                    res.fired_slot   = fired_list[k];
                    res.active_count = armed_total;
                    res.last         = (k == n_fired - 1);
                    expected_results.push_back(res);
                end
                fire_count += n_fired;
                if (n_fired > max_fires)
                    max_fires = n_fired;
            end
        endcase
    endtask

    // One random item, weighted toward ticks and short intervals.
    function automatic t_item random_item();
        t_item      it;
        int unsigned pick;
        it = make_item(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom(),
                       1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.func = FUNC_TICK;
        end else if (pick < 65) begin
            it.func = FUNC_ATTACH;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                it.interval = $urandom_range(0, 6);
                it.interval_in_seconds = 1'b0;
            end else if (pick < 85) begin
                it.interval_in_seconds = 1'b0;
            end else begin
                it.interval_in_seconds = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
                it.repeat_count = 16'($urandom_range(0, 3));
            else if (pick < 8)
                it.repeat_count = '0;
        end else if (pick < 80) begin
            it.func = FUNC_QUERY;
        end else begin
            it.func = FUNC_DETACH;
        end
        return it;
    endfunction

    // Driver: a transfer happens at an edge with start high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                timer_table_step(i_item);
                accepted_count++;
            end
            if (!start || !busy) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    start <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                        // This cycle is the first of the idle burst.
                        idle_left <= $urandom_range(0, 9);
                        start <= 1'b0;
                    end else begin
                        i_item <= pending_items.pop_front();
                        start <= 1'b1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation waiting: %p", o_result);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.fired !== want.fired) begin
                    $error("fired: expected %0d, actual %0d", want.fired, o_result.fired);
                    error_count++;
                end
                if (o_result.fired_slot !== want.fired_slot) begin
                    $error("fired_slot: expected %0d, actual %0d",
                           want.fired_slot, o_result.fired_slot);
                    error_count++;
                end
                if (o_result.remaining !== want.remaining) begin
                    $error("remaining: expected %0d, actual %0d",
                           want.remaining, o_result.remaining);
                    error_count++;
                end
                if (o_result.active_count !== want.active_count) begin
                    $error("active_count: expected %0d, actual %0d",
                           want.active_count, o_result.active_count);
                    error_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int random_count;
        clear_timer_table();

        // Directed part: empty slots, restarts, field extremes, wrapped seconds.
        pending_items.push_back(make_item(FUNC_QUERY,  4'd0,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_DETACH, 4'd15, '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd0,  32'd0, 1'b0, 16'd0));
        pending_items.push_back(make_item(FUNC_QUERY,  4'd0,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd0,  32'd0, 1'b0, 16'd0));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd15, '1, 1'b0, '1));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd3,  32'd3, 1'b1, 16'd2));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd5,  '1, 1'b1, 16'd1));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd7,  32'd2, 1'b0, 16'd1));
        pending_items.push_back(make_item(FUNC_QUERY,  4'd15, '1, 1'b1, '1));
        pending_items.push_back(make_item(FUNC_QUERY,  4'd5,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_TICK,   4'd0,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_TICK,   4'd15, '1, 1'b1, '1));
        pending_items.push_back(make_item(FUNC_QUERY,  4'd7,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_QUERY,  4'd3,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_DETACH, 4'd0,  '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_DETACH, 4'd0,  '1, 1'b1, '1));
        pending_items.push_back(make_item(FUNC_DETACH, 4'd15, '0, 1'b0, '0));
        pending_items.push_back(make_item(FUNC_ATTACH, 4'd9,  32'd1, 1'b0, 16'd3));
        repeat (4)
            pending_items.push_back(make_item(FUNC_TICK, 4'd0, '0, 1'b0, '0));

        // Random part, with occasional bursts that arm every slot in turn.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                for (int s = 0; s < SLOTS; s++)
                    pending_items.push_back(make_item(FUNC_ATTACH, 4'(s),
                        $urandom_range(0, 1), 1'b0, 16'($urandom_range(0, 2))));
                repeat (3)
                    pending_items.push_back(make_item(FUNC_TICK, 4'($urandom_range(0, 15)),
                        $urandom(), 1'b0, '0));
                random_count += SLOTS + 3;
            end else begin
                pending_items.push_back(random_item());
                random_count++;
            end
        end
        total_items = pending_items.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d attach, %0d detach, %0d tick, %0d query.",
                 total_items, func_count[FUNC_ATTACH], func_count[FUNC_DETACH],
                 func_count[FUNC_TICK], func_count[FUNC_QUERY]);
        $display("Saw %0d slot expirations, up to %0d in a single tick.",
                 fire_count, max_fires);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mst_pkg.sv
rtl/core/mst_slot_mem.sv
rtl/core/multi_slot_repeat_timer.sv
sim/tb_top.sv
